// ----- hdl/segi_pkg.sv -----
// Shared widths, status codes, pipeline payload types and helpers for the
// segment intersection core. No dependencies.
package segi_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int REM_W      = CROSS_W + 1;
    localparam int RATIO_BITS = 32;
    localparam int Q_W        = RATIO_BITS + 1;
    localparam int DIV_STAGES = Q_W;
    localparam int TOL_W      = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd1;

    typedef enum logic [2:0] {
        ST_CROSS     = 3'd0,
        ST_COLL_A    = 3'd1,
        ST_COLL_C    = 3'd2,
        ST_COLL_NONE = 3'd3,
        ST_PARALLEL  = 3'd4,
        ST_OUTSIDE   = 3'd5
    } status_t;

    // Cross products and the coordinates still needed after them.
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] dx;
        logic signed [DIFF_W-1:0]  bax;
        logic signed [DIFF_W-1:0]  bay;
        logic signed [CROSS_W-1:0] den;
        logic signed [CROSS_W-1:0] rn;
        logic signed [CROSS_W-1:0] sn;
    } cross_t;

    // Result fields carried alongside the divider. For a crossing, px and py
    // hold the start point A until the interpolation adds the offset.
    typedef struct packed {
        logic                      found;
        status_t                   status;
        logic                      crossing;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [DIFF_W-1:0]  bax;
        logic signed [DIFF_W-1:0]  bay;
    } side_t;

    function automatic logic [CROSS_W-1:0] mag_cross(input logic signed [CROSS_W-1:0] v);
        mag_cross = v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

    function automatic logic near_zero(input logic signed [CROSS_W-1:0] v,
                                       input logic [TOL_W-1:0] tol);
        near_zero = (v == '0) || (mag_cross(v) < {{(CROSS_W-TOL_W){1'b0}}, tol});
    endfunction

    // True when n/d lies in [0,1]; d is known to be nonzero.
    function automatic logic unit_ratio(input logic signed [CROSS_W-1:0] n,
                                        input logic signed [CROSS_W-1:0] d);
        if (!d[CROSS_W-1])
            unit_ratio = (n >= 0) && (n <= d);
        else
            unit_ratio = (n <= 0) && (n >= d);
    endfunction

endpackage

// ----- hdl/segi_cross.sv -----
// Three pipeline stages: coordinate differences, six products, cross sums.
// Depends on segi_pkg.
module segi_cross
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [segi_pkg::COORD_W-1:0] a_x,
    input  logic signed [segi_pkg::COORD_W-1:0] a_y,
    input  logic signed [segi_pkg::COORD_W-1:0] b_x,
    input  logic signed [segi_pkg::COORD_W-1:0] b_y,
    input  logic signed [segi_pkg::COORD_W-1:0] c_x,
    input  logic signed [segi_pkg::COORD_W-1:0] c_y,
    input  logic signed [segi_pkg::COORD_W-1:0] d_x,
    input  logic signed [segi_pkg::COORD_W-1:0] d_y,
    output logic                                out_valid,
    output segi_pkg::cross_t                    out_data
);

    localparam int CW = segi_pkg::COORD_W;
    localparam int DW = segi_pkg::DIFF_W;
    localparam int PW = segi_pkg::PROD_W;
    localparam int XW = segi_pkg::CROSS_W;

    logic [2:0] valid_reg;

    logic signed [CW-1:0] ax1_reg, ay1_reg, bx1_reg, cx1_reg, cy1_reg, dx1_reg;
    logic signed [DW-1:0] bax1_reg, bay1_reg, dcx1_reg, dcy1_reg, acx1_reg, acy1_reg;

    logic signed [CW-1:0] ax2_reg, ay2_reg, bx2_reg, cx2_reg, cy2_reg, dx2_reg;
    logic signed [DW-1:0] bax2_reg, bay2_reg;
    logic signed [PW-1:0] p_bd_reg, p_bc_reg, p_rd_reg, p_rc_reg, p_sa_reg, p_sb_reg;

    segi_pkg::cross_t data3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: differences, one bit wider than the coordinates.
        ax1_reg  <= a_x;
        ay1_reg  <= a_y;
        bx1_reg  <= b_x;
        cx1_reg  <= c_x;
        cy1_reg  <= c_y;
        dx1_reg  <= d_x;
        bax1_reg <= DW'(b_x) - DW'(a_x);
        bay1_reg <= DW'(b_y) - DW'(a_y);
        dcx1_reg <= DW'(d_x) - DW'(c_x);
        dcy1_reg <= DW'(d_y) - DW'(c_y);
        acx1_reg <= DW'(a_x) - DW'(c_x);
        acy1_reg <= DW'(a_y) - DW'(c_y);

        // Stage 2: the six products.
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        bx2_reg  <= bx1_reg;
        cx2_reg  <= cx1_reg;
        cy2_reg  <= cy1_reg;
        dx2_reg  <= dx1_reg;
        bax2_reg <= bax1_reg;
        bay2_reg <= bay1_reg;
        p_bd_reg <= PW'(bax1_reg) * PW'(dcy1_reg);
        p_bc_reg <= PW'(bay1_reg) * PW'(dcx1_reg);
        p_rd_reg <= PW'(acy1_reg) * PW'(dcx1_reg);
        p_rc_reg <= PW'(acx1_reg) * PW'(dcy1_reg);
        p_sa_reg <= PW'(acy1_reg) * PW'(bax1_reg);
        p_sb_reg <= PW'(acx1_reg) * PW'(bay1_reg);

        // Stage 3: denominator and the two numerators.
        data3_reg.ax  <= ax2_reg;
        data3_reg.ay  <= ay2_reg;
        data3_reg.bx  <= bx2_reg;
        data3_reg.cx  <= cx2_reg;
        data3_reg.cy  <= cy2_reg;
        data3_reg.dx  <= dx2_reg;
        data3_reg.bax <= bax2_reg;
        data3_reg.bay <= bay2_reg;
        data3_reg.den <= XW'(p_bd_reg) - XW'(p_bc_reg);
        data3_reg.rn  <= XW'(p_rd_reg) - XW'(p_rc_reg);
        data3_reg.sn  <= XW'(p_sa_reg) - XW'(p_sb_reg);
    end

    assign out_valid = valid_reg[2];
    assign out_data  = data3_reg;

endmodule

// ----- hdl/segi_classify.sv -----
// One stage that sorts a pair into collinear, parallel, outside or crossing
// and prepares the divider operands. Depends on segi_pkg.
module segi_classify
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [segi_pkg::TOL_W-1:0]        tol,
    input  logic                              in_valid,
    input  segi_pkg::cross_t                  in_data,
    output logic                              out_valid,
    output segi_pkg::side_t                   out_side,
    output logic [segi_pkg::CROSS_W-1:0]      out_n,
    output logic [segi_pkg::CROSS_W-1:0]      out_d
);

    logic                             valid_reg;
    segi_pkg::side_t                  side_reg;
    segi_pkg::side_t                  side_next;
    logic [segi_pkg::CROSS_W-1:0]     n_reg;
    logic [segi_pkg::CROSS_W-1:0]     d_reg;

    always_comb
    begin
        side_next          = '0;
        side_next.bax      = in_data.bax;
        side_next.bay      = in_data.bay;
        side_next.status   = segi_pkg::ST_CROSS;
        if (segi_pkg::near_zero(in_data.den, tol))
        begin
            if (segi_pkg::near_zero(in_data.rn, tol))
            begin
                // Overlap of collinear segments is judged on x alone.
                if (in_data.ax >= in_data.cx && in_data.ax <= in_data.dx)
                begin
                    side_next.found  = 1'b1;
                    side_next.status = segi_pkg::ST_COLL_A;
                    side_next.px     = in_data.ax;
                    side_next.py     = in_data.ay;
                end
                else if (in_data.cx >= in_data.ax && in_data.cx <= in_data.bx)
                begin
                    side_next.found  = 1'b1;
                    side_next.status = segi_pkg::ST_COLL_C;
                    side_next.px     = in_data.cx;
                    side_next.py     = in_data.cy;
                end
                else
                begin
                    side_next.status = segi_pkg::ST_COLL_NONE;
                end
            end
            else
            begin
                side_next.status = segi_pkg::ST_PARALLEL;
            end
        end
        else if (!segi_pkg::unit_ratio(in_data.rn, in_data.den) ||
                 !segi_pkg::unit_ratio(in_data.sn, in_data.den))
        begin
            side_next.status = segi_pkg::ST_OUTSIDE;
        end
        else
        begin
            side_next.found    = 1'b1;
            side_next.crossing = 1'b1;
            side_next.px       = in_data.ax;
            side_next.py       = in_data.ay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        n_reg    <= segi_pkg::mag_cross(in_data.rn);
        d_reg    <= segi_pkg::mag_cross(in_data.den);
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_n     = n_reg;
    assign out_d     = d_reg;

endmodule

// ----- hdl/segi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, forming
// floor(n * 2^32 / d) for n <= d. Depends on segi_pkg.
module segi_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  segi_pkg::side_t                   in_side,
    input  logic [segi_pkg::CROSS_W-1:0]      in_n,
    input  logic [segi_pkg::CROSS_W-1:0]      in_d,
    output logic                              out_valid,
    output segi_pkg::side_t                   out_side,
    output logic [segi_pkg::Q_W-1:0]          out_q,
    output logic [segi_pkg::REM_W-1:0]        out_rem,
    output logic [segi_pkg::CROSS_W-1:0]      out_d
);

    localparam int NS = segi_pkg::DIV_STAGES;
    localparam int RW = segi_pkg::REM_W;
    localparam int XW = segi_pkg::CROSS_W;
    localparam int QW = segi_pkg::Q_W;

    logic [NS-1:0]         valid_reg;
    logic [RW-1:0]         rem_reg  [0:NS-1];
    logic [QW-1:0]         q_reg    [0:NS-1];
    logic [XW-1:0]         d_reg    [0:NS-1];
    segi_pkg::side_t       side_reg [0:NS-1];

    logic [RW-1:0]         trial    [0:NS-1];
    logic [QW-1:0]         q_src    [0:NS-1];
    logic [XW-1:0]         d_src    [0:NS-1];
    segi_pkg::side_t       side_src [0:NS-1];

    // The first stage tests n against d without a shift; that bit is the
    // integer part of the ratio, set only when n equals d.
    always_comb
    begin
        trial[0]    = RW'(in_n);
        q_src[0]    = '0;
        d_src[0]    = in_d;
        side_src[0] = in_side;
        for (int j = 1; j < NS; j++)
        begin
            trial[j]    = {rem_reg[j-1][RW-2:0], 1'b0};
            q_src[j]    = q_reg[j-1];
            d_src[j]    = d_reg[j-1];
            side_src[j] = side_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            d_reg[j]    <= d_src[j];
            side_reg[j] <= side_src[j];
            if (trial[j] >= RW'(d_src[j]))
            begin
                rem_reg[j] <= trial[j] - RW'(d_src[j]);
                q_reg[j]   <= {q_src[j][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j] <= trial[j];
                q_reg[j]   <= {q_src[j][QW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_rem   = rem_reg[NS-1];
    assign out_d     = d_reg[NS-1];

endmodule

// ----- hdl/segi_lerp.sv -----
// Rounds the ratio, scales both deltas by it and, for a crossing, adds the start point:
// three stages, the last one being the result register. Depends on segi_pkg.
module segi_lerp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  segi_pkg::side_t                     in_side,
    input  logic [segi_pkg::Q_W-1:0]            in_q,
    input  logic [segi_pkg::REM_W-1:0]          in_rem,
    input  logic [segi_pkg::CROSS_W-1:0]        in_d,
    output logic                                done,
    output logic                                found,
    output logic [2:0]                          status,
    output logic signed [segi_pkg::COORD_W-1:0] point_x,
    output logic signed [segi_pkg::COORD_W-1:0] point_y
);

    localparam int QW = segi_pkg::Q_W;
    localparam int DW = segi_pkg::DIFF_W;
    localparam int MW = segi_pkg::Q_W + segi_pkg::DIFF_W;
    localparam int OW = MW - segi_pkg::RATIO_BITS;
    localparam int CW = segi_pkg::COORD_W;
    localparam int RB = segi_pkg::RATIO_BITS;

    logic [2:0]             valid_reg;
    segi_pkg::side_t        side1_reg, side2_reg;
    logic [QW-1:0]          rq_reg;
    logic [MW-1:0]          mx_reg, my_reg;
    logic                   found_reg;
    logic [2:0]             status_reg;
    logic signed [CW-1:0]   px_reg, py_reg;

    logic                   round_up;
    logic [DW-1:0]          mag_x, mag_y;
    logic [MW-1:0]          tx, ty;
    logic [OW-1:0]          off_x, off_y;
    logic [OW-1:0]          sum_x, sum_y;

    assign round_up = {in_rem, 1'b0} >= (segi_pkg::REM_W + 1)'(in_d);
    assign mag_x    = side1_reg.bax[DW-1] ? DW'(-side1_reg.bax) : DW'(side1_reg.bax);
    assign mag_y    = side1_reg.bay[DW-1] ? DW'(-side1_reg.bay) : DW'(side1_reg.bay);

    // Offsets round half away from zero, applied with the sign of the delta.
    assign tx    = mx_reg + (MW'(1) << (RB - 1));
    assign ty    = my_reg + (MW'(1) << (RB - 1));
    assign off_x = tx[MW-1:RB];
    assign off_y = ty[MW-1:RB];
    assign sum_x = side2_reg.bax[DW-1] ? OW'(side2_reg.px) - off_x : OW'(side2_reg.px) + off_x;
    assign sum_y = side2_reg.bay[DW-1] ? OW'(side2_reg.py) - off_y : OW'(side2_reg.py) + off_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        side1_reg  <= in_side;
        rq_reg     <= in_q + QW'(round_up);

        side2_reg  <= side1_reg;
        mx_reg     <= MW'(rq_reg) * MW'(mag_x);
        my_reg     <= MW'(rq_reg) * MW'(mag_y);

        found_reg  <= side2_reg.found;
        status_reg <= side2_reg.status;
        px_reg     <= side2_reg.crossing ? sum_x[CW-1:0] : side2_reg.px;
        py_reg     <= side2_reg.crossing ? sum_y[CW-1:0] : side2_reg.py;
    end

    assign done    = valid_reg[2];
    assign found   = found_reg;
    assign status  = status_reg;
    assign point_x = px_reg;
    assign point_y = py_reg;

endmodule

// ----- hdl/segment_intersection_core.sv -----
// Segment intersection core: a pipeline of 3 cross-product stages,
// 1 classification stage, 33 divider stages (one quotient bit each)
// and 3 interpolation stages from start to done.
// Throughput: one transaction per cycle; busy is always low.
// Reset clears all valid bits and sets the tolerance register to 1.
// Depends on segi_pkg, segi_cross, segi_classify, segi_div, segi_lerp.
module segment_intersection_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [segi_pkg::TOL_W-1:0]          cfg_wdata,
    input  logic signed [segi_pkg::COORD_W-1:0] a_x,
    input  logic signed [segi_pkg::COORD_W-1:0] a_y,
    input  logic signed [segi_pkg::COORD_W-1:0] b_x,
    input  logic signed [segi_pkg::COORD_W-1:0] b_y,
    input  logic signed [segi_pkg::COORD_W-1:0] c_x,
    input  logic signed [segi_pkg::COORD_W-1:0] c_y,
    input  logic signed [segi_pkg::COORD_W-1:0] d_x,
    input  logic signed [segi_pkg::COORD_W-1:0] d_y,
    output logic                                done,
    output logic                                found,
    output logic [2:0]                          status,
    output logic signed [segi_pkg::COORD_W-1:0] point_x,
    output logic signed [segi_pkg::COORD_W-1:0] point_y
);

    logic [segi_pkg::TOL_W-1:0]     tol_reg;
    logic                           cross_valid;
    segi_pkg::cross_t               cross_data;
    logic                           cls_valid;
    segi_pkg::side_t                cls_side;
    logic [segi_pkg::CROSS_W-1:0]   cls_n, cls_d;
    logic                           div_valid;
    segi_pkg::side_t                div_side;
    logic [segi_pkg::Q_W-1:0]       div_q;
    logic [segi_pkg::REM_W-1:0]     div_rem;
    logic [segi_pkg::CROSS_W-1:0]   div_d;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= segi_pkg::TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    segi_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .d_x       (d_x),
        .d_y       (d_y),
        .out_valid (cross_valid),
        .out_data  (cross_data)
    );

    segi_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .in_valid  (cross_valid),
        .in_data   (cross_data),
        .out_valid (cls_valid),
        .out_side  (cls_side),
        .out_n     (cls_n),
        .out_d     (cls_d)
    );

    segi_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_side   (cls_side),
        .in_n      (cls_n),
        .in_d      (cls_d),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_q     (div_q),
        .out_rem   (div_rem),
        .out_d     (div_d)
    );

    segi_lerp u_lerp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .in_q      (div_q),
        .in_rem    (div_rem),
        .in_d      (div_d),
        .done      (done),
        .found     (found),
        .status    (status),
        .point_x   (point_x),
        .point_y   (point_y)
    );

    // Every transaction that enters comes out as a done strobe at the end of the pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##40 done)
        else $error("result strobe missing after pipeline latency");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (found == (status == segi_pkg::ST_CROSS || status == segi_pkg::ST_COLL_A ||
                            status == segi_pkg::ST_COLL_C)))
        else $error("found flag disagrees with status");

    a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (point_x == '0 && point_y == '0))
        else $error("point reported without a found result");

endmodule

// ----- tb/sv/segment_intersection_checker.sv -----
`timescale 1ns / 100ps
// Checker for the segment intersection core: watches the input, configuration and
// result channels, predicts each result and compares it field by field.
// Depends on segi_pkg for the status codes and widths.
module segment_intersection_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                cfg_we,
    input  logic [segi_pkg::TOL_W-1:0]          cfg_wdata,
    input  logic signed [segi_pkg::COORD_W-1:0] a_x,
    input  logic signed [segi_pkg::COORD_W-1:0] a_y,
    input  logic signed [segi_pkg::COORD_W-1:0] b_x,
    input  logic signed [segi_pkg::COORD_W-1:0] b_y,
    input  logic signed [segi_pkg::COORD_W-1:0] c_x,
    input  logic signed [segi_pkg::COORD_W-1:0] c_y,
    input  logic signed [segi_pkg::COORD_W-1:0] d_x,
    input  logic signed [segi_pkg::COORD_W-1:0] d_y,
    input  logic                                done,
    input  logic                                found,
    input  logic [2:0]                          status,
    input  logic signed [segi_pkg::COORD_W-1:0] point_x,
    input  logic signed [segi_pkg::COORD_W-1:0] point_y,
    output int                                  mismatches,
    output int                                  outstanding
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                                found;
        segi_pkg::status_t                   status;
        logic signed [segi_pkg::COORD_W-1:0] px;
        logic signed [segi_pkg::COORD_W-1:0] py;
    } crossing_t;

    crossing_t                       crossing_q[$];
    logic [segi_pkg::TOL_W-1:0]      tolerance;

    function automatic logic is_negligible(wide_t v, logic [segi_pkg::TOL_W-1:0] tol);
        wide_t m;
        m = (v < 0) ? -v : v;
        return (v == 0) || (m < $signed({96'b0, tol}));
    endfunction

    function automatic logic in_unit(wide_t n, wide_t d);
        if (d >= 0)
            return (n >= 0) && (n <= d);
        return (n <= 0) && (n >= d);
    endfunction

    // Offset of rq * |delta| rounded to nearest, applied in the direction of delta.
    function automatic logic signed [segi_pkg::COORD_W-1:0] interp_coord(wide_t a,
                                                                         wide_t delta,
                                                                         logic [63:0] rq);
        logic [127:0] t;
        wide_t        off;
        t = {64'b0, rq} * ((delta < 0) ? -delta : delta) + (128'd1 << 31);
        off = $signed({64'b0, t[95:32]});
        return (delta < 0) ? segi_pkg::COORD_W'(a - off) : segi_pkg::COORD_W'(a + off);
    endfunction

    function automatic crossing_t predict_crossing(logic [segi_pkg::TOL_W-1:0] tol);
        wide_t        ax, ay, bx, by, cx, cy, dx, dy;
        wide_t        bax, bay, acx, acy, dcx, dcy, den, rn, sn;
        logic [127:0] sh, dd, q, rem;
        crossing_t    r;
        ax = a_x; ay = a_y; bx = b_x; by = b_y;
        cx = c_x; cy = c_y; dx = d_x; dy = d_y;
        bax = bx - ax; bay = by - ay;
        acx = ax - cx; acy = ay - cy;
        dcx = dx - cx; dcy = dy - cy;
        den = bax * dcy - bay * dcx;
        rn  = acy * dcx - acx * dcy;
        sn  = acy * bax - acx * bay;
        r.found = 1'b0; r.px = '0; r.py = '0;
        if (is_negligible(den, tol)) begin
            if (!is_negligible(rn, tol))
                r.status = segi_pkg::ST_PARALLEL;
            else if (ax >= cx && ax <= dx) begin
                r.found = 1'b1; r.status = segi_pkg::ST_COLL_A; r.px = a_x; r.py = a_y;
            end
            else if (cx >= ax && cx <= bx) begin
                r.found = 1'b1; r.status = segi_pkg::ST_COLL_C; r.px = c_x; r.py = c_y;
            end
            else
                r.status = segi_pkg::ST_COLL_NONE;
        end
        else if (!in_unit(rn, den) || !in_unit(sn, den))
            r.status = segi_pkg::ST_OUTSIDE;
        else begin
            sh  = ((rn < 0) ? -rn : rn) << segi_pkg::RATIO_BITS;
            dd  = (den < 0) ? -den : den;
            q   = sh / dd;
            rem = sh % dd;
            if ((rem << 1) >= dd)
                q = q + 1;
            r.found  = 1'b1;
            r.status = segi_pkg::ST_CROSS;
            r.px = interp_coord(ax, bax, q[63:0]);
            r.py = interp_coord(ay, bay, q[63:0]);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t e;
        if (!rst_n) begin
            tolerance   <= segi_pkg::TOL_RESET;
            mismatches  <= 0;
            outstanding <= 0;
            crossing_q.delete();
        end
        else begin
            if (done) begin
                if (crossing_q.size() == 0) begin
                    $error("result with no transaction waiting");
                    mismatches <= mismatches + 1;
                end
                else begin
                    e = crossing_q.pop_front();
                    if (found !== e.found || status !== e.status ||
                        point_x !== e.px || point_y !== e.py) begin
                        mismatches <= mismatches + 1;
                        if (found !== e.found)
                            $error("found: expected %0d actual %0d", e.found, found);
                        if (status !== e.status)
                            $error("status: expected %0d actual %0d", e.status, status);
                        if (point_x !== e.px)
                            $error("point_x: expected %0d actual %0d", e.px, point_x);
                        if (point_y !== e.py)
                            $error("point_y: expected %0d actual %0d", e.py, point_y);
                    end
                end
            end
            if (start && !busy)
                crossing_q.push_back(predict_crossing(tolerance));
            if (cfg_we)
                tolerance <= cfg_wdata;
            outstanding <= crossing_q.size();
        end
    end

endmodule

// ----- tb/sv/segment_intersection_core_test.sv -----
`timescale 1ns / 100ps
// Testbench top for segment_intersection_core: clock, reset, directed and random
// segment pairs, tolerance changes and the verdict. Depends on segi_pkg,
// the core and segment_intersection_checker.
module segment_intersection_core_test;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 50;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic                                cfg_we;
    logic [segi_pkg::TOL_W-1:0]          cfg_wdata;
    logic signed [segi_pkg::COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    logic                                done;
    logic                                found;
    logic [2:0]                          status;
    logic signed [segi_pkg::COORD_W-1:0] point_x, point_y;
    int                                  mismatches;
    int                                  outstanding;
    int                                  stall_cycles;
    int                                  pairs_sent;
    int                                  tol_settings;
    int                                  idle_pct;

    segment_intersection_core DUT
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
        .c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
        .done(done), .found(found), .status(status),
        .point_x(point_x), .point_y(point_y)
    );

    segment_intersection_checker u_checker
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
        .c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
        .done(done), .found(found), .status(status),
        .point_x(point_x), .point_y(point_y),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: cycles in which neither a transaction nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called right after a rising edge; leaves on the edge that takes the pair.
    task automatic send_pair(input longint p[8]);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        a_x <= segi_pkg::COORD_W'(p[0]); a_y <= segi_pkg::COORD_W'(p[1]);
        b_x <= segi_pkg::COORD_W'(p[2]); b_y <= segi_pkg::COORD_W'(p[3]);
        c_x <= segi_pkg::COORD_W'(p[4]); c_y <= segi_pkg::COORD_W'(p[5]);
        d_x <= segi_pkg::COORD_W'(p[6]); d_y <= segi_pkg::COORD_W'(p[7]);
        start <= 1'b1;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        pairs_sent++;
    endtask

    task automatic drain_and_set_tolerance(input logic [segi_pkg::TOL_W-1:0] v);
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_settings++;
    endtask

    function automatic longint near_coord();
        return longint'($urandom_range(0, 2097152)) - 1048576;
    endfunction

    task automatic make_pair(output longint p[8]);
        longint k, m, wx, wy, qx, qy, ux, uy, ox, oy;
        int     kind;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // Crossing by construction: C and D straddle a point on A-B.
            for (int i = 0; i < 4; i++) p[i] = near_coord();
            k  = $urandom_range(0, 1024);
            qx = p[0] + ((p[2] - p[0]) * k) / 1024;
            qy = p[1] + ((p[3] - p[1]) * k) / 1024;
            wx = near_coord(); wy = near_coord();
            m  = $urandom_range(0, 512);
            p[4] = qx + wx; p[5] = qy + wy;
            p[6] = qx - (wx * m) / 256; p[7] = qy - (wy * m) / 256;
        end
        else if (kind < 65) begin
            // Points on one line; with an offset on C-D the lines are parallel.
            qx = near_coord(); qy = near_coord();
            ux = longint'($urandom_range(0, 8192)) - 4096;
            uy = longint'($urandom_range(0, 8192)) - 4096;
            for (int i = 0; i < 4; i++) begin
                k = longint'($urandom_range(0, 400)) - 200;
                p[2*i] = qx + k * ux; p[2*i+1] = qy + k * uy;
            end
            if (kind >= 55) begin
                ox = longint'($urandom_range(1, 5000)); oy = longint'($urandom_range(0, 5000));
                p[4] += ox; p[6] += ox; p[5] += oy; p[7] += oy;
            end
        end
        else if (kind < 80) begin
            for (int i = 0; i < 8; i++) p[i] = near_coord();
        end
        else begin
            for (int i = 0; i < 8; i++) p[i] = longint'($signed($urandom));
        end
    endtask

    task automatic random_phase(input int count);
        longint p[8];
        for (int n = 0; n < count; n++) begin
            make_pair(p);
            send_pair(p);
        end
    endtask

    task automatic send8(input longint v0, v1, v2, v3, v4, v5, v6, v7);
        longint p[8];
        p = '{v0, v1, v2, v3, v4, v5, v6, v7};
        send_pair(p);
    endtask

    initial
    begin
        longint one, mx, mn;
        one = 65536; mx = 2147483647; mn = -mx - 1;
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
        a_x = '0; a_y = '0; b_x = '0; b_y = '0; c_x = '0; c_y = '0; d_x = '0; d_y = '0;
        pairs_sent = 0; tol_settings = 0; idle_pct = 30;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at the reset tolerance.
        send8(0, 0, 0, 0, 0, 0, 0, 0);
        send8(0, 0, 2*one, 2*one, 0, 2*one, 2*one, 0);
        send8(0, 0, 3*one, one, 0, one, one, 0);
        send8(0, 0, one, 0, 0, 0, 0, one);
        send8(0, 0, one, one, one, one, 2*one, 0);
        send8(0, 0, 4*one, 0, -one, 0, 2*one, 0);
        send8(one, 0, 4*one, 0, -one, 0, 0, 0);
        send8(0, 0, 4*one, 0, 5*one, 0, 6*one, 0);
        send8(0, 0, 4*one, 0, 0, one, 4*one, one);
        send8(0, 0, one, one, 3*one, 0, 3*one, 5*one);
        send8(0, 0, one, 0, 2*one, -one, 2*one, one);
        send8(mx, mx, mn, mn, mx, mn, mn, mx);
        send8(mn, mn, mx, mx, mn, mx, mx, mn);
        send8(mx, mx, mx, mx, mx, mx, mx, mx);
        send8(mn, mn, mn, mn, mn, mn, mn, mn);
        send8(-1, -1, 1, 1, -1, 1, 1, -1);
        send8(0, 0, 7, 3, 0, 3, 7, 0);
        send8(mn, 0, mx, 0, 0, mn, 0, mx);

        drain_and_set_tolerance(32'd0);
        send8(0, 0, 4*one, 0, 5*one, 0, 6*one, 0);
        send8(0, 0, 2*one, 2*one, 0, 2*one, 2*one, 0);
        random_phase(300);

        // Sender never idles through this setting.
        drain_and_set_tolerance($urandom);
        idle_pct = 0;
        random_phase(400);
        idle_pct = 30;

        drain_and_set_tolerance(32'hFFFF_FFFF);
        random_phase(250);

        drain_and_set_tolerance(32'd1 << $urandom_range(0, 31));
        random_phase(300);

        drain_and_set_tolerance($urandom_range(0, 65535));
        random_phase(250);

        drain_and_set_tolerance(32'd1);
        random_phase(300);

        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d segment pairs over %0d tolerance settings plus reset,",
                 pairs_sent, tol_settings);
        $display("with crossing, collinear, parallel and extreme-coordinate pairs.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
